// ----- design/alh_pkg.sv -----
// Shared constants and types for the adjacency-list header and page layout block.
`default_nettype none

package alh_pkg;

  // Default chunk size in nodes
  localparam int unsigned ChunkNodesDef = 512;

  // Field widths
  localparam int unsigned LenW      = 32;
  localparam int unsigned HdrCapW   = 12;
  localparam int unsigned PgCapW    = 13;
  localparam int unsigned OffsW     = 20;
  localparam int unsigned LliW      = 31;
  localparam int unsigned CpiW      = 20;
  localparam int unsigned PageW     = 32;
  localparam int unsigned HdrLenW   = 11;
  localparam int unsigned CfgDataW  = 13;

  // Divider: dividend width and iteration counts
  localparam int unsigned DivW       = 33;
  localparam int unsigned SmallDivW  = 14;
  localparam int unsigned DivCntW    = 6;

  // Register reset values
  localparam logic [HdrCapW-1:0] HdrCapRst = HdrCapW'(512);
  localparam logic [PgCapW-1:0]  PgCapRst  = PgCapW'(512);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_HDR_CAP = 1'b0,
    CFG_PG_CAP  = 1'b1
  } cfg_idx_e;

  // Result kinds
  typedef enum logic [0:0] {
    KIND_NODE  = 1'b0,
    KIND_CHUNK = 1'b1
  } item_kind_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_NODE  = 4'b0100,
    S_CHUNK = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ----- design/adjacency_list_header_page_layout.sv -----
// Adjacency-list header and page layout unit with a bit-serial shared divider.
// A large list's header result is loaded after 33 divider steps, a small list's after
// 14 divider steps; at a chunk end a chunk result follows. A new item is accepted only
// once the previous one is through. The divider is a one-bit-per-cycle restoring divider;
// output stalls hold results back.
// Reset (asynchronous, active low) clears all layout state and sets both capacities to 512.
`default_nettype none

module adjacency_list_header_page_layout
  #(
    parameter int unsigned CHUNK_NODES = alh_pkg::ChunkNodesDef
  )
  (
    input  wire logic                        clk_i,
    input  wire logic                        rst_ni,
    // Configuration write port
    input  wire logic                        cfg_we_i,
    input  wire alh_pkg::cfg_idx_e           cfg_index_i,
    input  wire logic [alh_pkg::CfgDataW-1:0] cfg_data_i,
    // Input channel
    input  wire logic                        in_valid_i,
    output logic                             in_stall_o,
    input  wire logic [alh_pkg::LenW-1:0]    list_length_i,
    input  wire logic                        last_node_i,
    // Output channel
    output logic                             out_valid_o,
    input  wire logic                        out_stall_i,
    output logic                             item_kind_o,
    output logic [alh_pkg::PageW-1:0]        header_o,
    output logic [alh_pkg::PageW-1:0]        first_page_o,
    output logic [alh_pkg::PageW-1:0]        page_count_o,
    output logic [alh_pkg::PageW-1:0]        pages_so_far_o,
    output logic                             last_of_run_o
  );

  import alh_pkg::*;

  localparam int unsigned NicW = (CHUNK_NODES > 1) ? $clog2(CHUNK_NODES) : 1;

  // Configuration
  logic [HdrCapW-1:0] hdr_cap_q;
  logic [PgCapW-1:0]  pg_cap_q;

  // Label state
  logic [OffsW-1:0]  offset_q;
  logic [LliW-1:0]   lli_q;
  logic [NicW-1:0]   nic_q;
  logic [CpiW-1:0]   cpi_q;
  logic [PgCapW-1:0] fill_q;
  logic [PageW-1:0]  ngp_q;

  // Item and divider registers
  state_e             state_q, state_d;
  logic [LenW-1:0]    len_q;
  logic               last_q;
  logic               large_q;
  logic               tot_zero_q;
  logic [PgCapW-1:0]  cap_q;
  logic [DivW-1:0]    dq_q;
  logic [PgCapW-1:0]  rem_q;
  logic [DivCntW-1:0] cnt_q;

  // Output register
  logic               out_valid_q;
  logic               kind_q;
  logic [PageW-1:0]   header_q;
  logic [PageW-1:0]   first_q;
  logic [PageW-1:0]   count_q;
  logic [PageW-1:0]   so_far_q;
  logic               lor_q;

  // Accept-time setup
  logic                 in_acc;
  logic [PgCapW-1:0]    cap_eff;
  logic                 is_large;
  logic [SmallDivW-1:0] total;
  logic [SmallDivW-1:0] total_m1;
  logic [DivW-1:0]      large_dvd;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign cap_eff   = (pg_cap_q == '0) ? PgCapW'(1) : pg_cap_q;
  assign is_large  = list_length_i >= {{(LenW-HdrCapW){1'b0}}, hdr_cap_q};
  assign total     = {1'b0, fill_q} + {{(SmallDivW-HdrCapW){1'b0}}, list_length_i[HdrCapW-1:0]};
  assign total_m1  = (total == '0) ? '0 : total - SmallDivW'(1);
  assign large_dvd = {1'b0, list_length_i} + {{(DivW-PgCapW){1'b0}}, cap_eff} - DivW'(1);

  // Divider step: shift one dividend bit into the remainder, try a subtract
  logic [PgCapW:0] shifted;
  logic            ge;
  logic [PgCapW:0] diff;

  assign shifted = {rem_q, dq_q[DivW-1]};
  assign ge      = shifted >= {1'b0, cap_q};
  assign diff    = shifted - {1'b0, cap_q};

  // Node result arithmetic
  logic [PageW-1:0]     pages;
  logic [PageW:0]       ngp_sum;
  logic [PageW-1:0]     ngp_large;
  logic [SmallDivW-1:0] adv;
  logic [CpiW:0]        cpi_sum;
  logic [CpiW-1:0]      cpi_small;
  logic [PgCapW-1:0]    fill_small;
  logic [NicW:0]        nic_inc;
  logic                 chunk_end;

  assign pages      = dq_q[PageW-1:0];
  assign ngp_sum    = {1'b0, ngp_q} + {1'b0, pages};
  assign ngp_large  = ngp_sum[PageW] ? '1 : ngp_sum[PageW-1:0];
  assign adv        = dq_q[SmallDivW-1:0];
  assign cpi_sum    = {1'b0, cpi_q} + {{(CpiW+1-SmallDivW){1'b0}}, adv};
  assign cpi_small  = cpi_sum[CpiW] ? '1 : cpi_sum[CpiW-1:0];
  assign fill_small = tot_zero_q ? '0 : rem_q + PgCapW'(1);
  assign nic_inc    = {1'b0, nic_q} + (NicW+1)'(1);
  assign chunk_end  = last_q || (nic_inc >= (NicW+1)'(CHUNK_NODES));

  // Chunk result arithmetic
  logic             chunk_used;
  logic [PageW-1:0] chunk_cnt;
  logic [PageW:0]   chunk_sum;
  logic [PageW-1:0] ngp_chunk;

  assign chunk_used = (cpi_q != '0) || (fill_q != '0);
  assign chunk_cnt  = {{(PageW-CpiW){1'b0}}, cpi_q} + PageW'(1);
  assign chunk_sum  = {1'b0, ngp_q} + {1'b0, chunk_cnt};
  assign ngp_chunk  = chunk_sum[PageW] ? '1 : chunk_sum[PageW-1:0];

  logic out_free;
  logic out_load;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = ((state_q == S_NODE) || (state_q == S_CHUNK)) && out_free;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == DivCntW'(1)) state_d = S_NODE;
      end
      S_NODE: begin
        if (out_free) state_d = chunk_end ? S_CHUNK : S_IDLE;
      end
      S_CHUNK: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and label state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hdr_cap_q   <= HdrCapRst;
      pg_cap_q    <= PgCapRst;
      offset_q    <= '0;
      lli_q       <= '0;
      nic_q       <= '0;
      cpi_q       <= '0;
      fill_q      <= '0;
      ngp_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Write configuration
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_HDR_CAP: hdr_cap_q <= cfg_data_i[HdrCapW-1:0];
          CFG_PG_CAP:  pg_cap_q  <= cfg_data_i[PgCapW-1:0];
          default: ;
        endcase
      end

      // Load a new result or drop a taken one
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) cnt_q <= is_large ? DivCntW'(DivW) : DivCntW'(SmallDivW);
        end
        S_DIV: begin
          cnt_q <= cnt_q - DivCntW'(1);
        end
        S_NODE: begin
          if (out_free) begin
            if (large_q) begin
              lli_q <= lli_q + LliW'(1);
              ngp_q <= ngp_large;
            end else begin
              offset_q <= offset_q + len_q[OffsW-1:0];
              fill_q   <= fill_small;
              cpi_q    <= cpi_small;
            end
            if (!chunk_end) nic_q <= nic_inc[NicW-1:0];
          end
        end
        S_CHUNK: begin
          if (out_free) begin
            nic_q       <= '0;
            offset_q    <= '0;
            cpi_q       <= '0;
            fill_q      <= '0;
            if (last_q) begin
              lli_q <= '0;
              ngp_q <= '0;
            end else if (chunk_used) begin
              ngp_q <= ngp_chunk;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Item, divider and output payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          len_q      <= list_length_i;
          last_q     <= last_node_i;
          large_q    <= is_large;
          tot_zero_q <= (total == '0);
          cap_q      <= cap_eff;
          rem_q      <= '0;
          dq_q       <= is_large ? large_dvd : {total_m1, {(DivW-SmallDivW){1'b0}}};
        end
      end
      S_DIV: begin
        rem_q <= ge ? diff[PgCapW-1:0] : shifted[PgCapW-1:0];
        dq_q  <= {dq_q[DivW-2:0], ge};
      end
      S_NODE: begin
        if (out_free) begin
          kind_q <= KIND_NODE;
          lor_q  <= !chunk_end;
          if (large_q) begin
            header_q <= {1'b1, lli_q};
            count_q  <= pages;
            first_q  <= (pages != '0) ? ngp_q : '0;
            so_far_q <= ngp_large;
          end else begin
            header_q <= {1'b0, offset_q, len_q[HdrLenW-1:0]};
            count_q  <= '0;
            first_q  <= '0;
            so_far_q <= ngp_q;
          end
        end
      end
      S_CHUNK: begin
        if (out_free) begin
          kind_q   <= KIND_CHUNK;
          lor_q    <= 1'b1;
          header_q <= '0;
          count_q  <= chunk_used ? chunk_cnt : '0;
          first_q  <= chunk_used ? ngp_q : '0;
          so_far_q <= chunk_used ? ngp_chunk : ngp_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign item_kind_o    = kind_q;
  assign header_o       = header_q;
  assign first_page_o   = first_q;
  assign page_count_o   = count_q;
  assign pages_so_far_o = so_far_q;
  assign last_of_run_o  = lor_q;

  // The divider remainder stays below the page capacity
  a_rem_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < cap_q))
    else $error("divider remainder not below capacity");

  // An accepted item always starts a division
  a_accept_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_DIV))
    else $error("accepted item did not start division");

  // A chunk result closes its run
  a_chunk_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && item_kind_o == KIND_CHUNK) |-> last_of_run_o)
    else $error("chunk result not last of run");

  // An empty page range has no first page
  a_empty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && page_count_o == '0) |-> (first_page_o == '0))
    else $error("empty range with nonzero first page");

endmodule

`default_nettype wire
